@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked while reset is high.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/bts_pkg.sv @@
// ----------------------------------------------------------------------------
// Buzzer tone sequencer package
// Types, codes, widths and the pattern ROM shared by the sequencer modules.
// ----------------------------------------------------------------------------
package bts_pkg;

   localparam int MAX_PATTERN_STEPS = 9;
   localparam int ROM_SLOTS         = 16;
   localparam int STEP_CAP          = (MAX_PATTERN_STEPS < ROM_SLOTS) ?
                                      MAX_PATTERN_STEPS : ROM_SLOTS;

   localparam int FREQ_W = 15;
   localparam int DUR_W  = 16;
   localparam int KIND_W = 2;
   localparam int PID_W  = 2;
   localparam int STEP_W = 4;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK    = 2'd0,
      KIND_TONE    = 2'd1,
      KIND_PATTERN = 2'd2
   } kind_type;

   localparam logic [PID_W-1:0] PAT_SUCCESS   = 2'd0;
   localparam logic [PID_W-1:0] PAT_BAD_READ  = 2'd1;
   localparam logic [PID_W-1:0] PAT_COMM_FAIL = 2'd2;
   localparam logic [PID_W-1:0] PAT_COUNT     = 2'd3;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [DUR_W-1:0]  dur;
   } step_type;

   typedef struct packed {
      logic              busy;
      logic              in_pattern;
      logic [PID_W-1:0]  current_pattern;
      logic [STEP_W-1:0] step_index;
      logic [DUR_W-1:0]  time_left;
      logic [FREQ_W-1:0] drive_freq;
   } seq_state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [FREQ_W-1:0] tone_freq;
      logic [DUR_W-1:0]  tone_duration;
      logic [PID_W-1:0]  pattern_id;
   } item_type;

   function automatic step_type mk_step(int f, int d);
      step_type s;
      s.freq = FREQ_W'(f);
      s.dur  = DUR_W'(d);
      return s;
   endfunction

   // Pattern ROM: slots past a pattern's end read as zero.
   function automatic step_type pattern_step(logic [PID_W-1:0] pat,
                                             logic [STEP_W-1:0] idx);
      step_type s;
      s = mk_step(0, 0);
      case (pat)
         PAT_SUCCESS: begin
            if (idx == 4'd0) s = mk_step(3000, 500);
         end
         PAT_BAD_READ: begin
            case (idx)
               4'd0:    s = mk_step(1500, 300);
               4'd1:    s = mk_step(0, 100);
               4'd2:    s = mk_step(1500, 300);
               default: s = mk_step(0, 0);
            endcase
         end
         PAT_COMM_FAIL: begin
            case (idx)
               4'd0:    s = mk_step(3000, 100);
               4'd1:    s = mk_step(0, 50);
               4'd2:    s = mk_step(2625, 100);
               4'd3:    s = mk_step(0, 50);
               4'd4:    s = mk_step(2250, 100);
               4'd5:    s = mk_step(0, 50);
               4'd6:    s = mk_step(1875, 100);
               4'd7:    s = mk_step(0, 50);
               4'd8:    s = mk_step(1500, 100);
               default: s = mk_step(0, 0);
            endcase
         end
         default: s = mk_step(0, 0);
      endcase
      return s;
   endfunction

   // Number of steps actually played, capped by the step limit.
   function automatic logic [STEP_W:0] pattern_len(logic [PID_W-1:0] pat);
      int n;
      case (pat)
         PAT_SUCCESS:   n = 1;
         PAT_BAD_READ:  n = 3;
         PAT_COMM_FAIL: n = 9;
         default:       n = 0;
      endcase
      if (n > STEP_CAP) n = STEP_CAP;
      return (STEP_W+1)'(n);
   endfunction

endpackage

@@ rtl/bts_next.sv @@
// ----------------------------------------------------------------------------
// Buzzer tone sequencer next-state logic
// Applies one tick or command to the sequencer state.
// ----------------------------------------------------------------------------
module bts_next (
   input  bts_pkg::seq_state_type cur,
   input  bts_pkg::item_type      item,
   output bts_pkg::seq_state_type nxt
);
   import bts_pkg::*;

   logic [STEP_W:0] step_next;
   step_type        next_step;
   step_type        first_step;

   assign step_next  = {1'b0, cur.step_index} + (STEP_W+1)'(1);
   assign next_step  = pattern_step(cur.current_pattern, step_next[STEP_W-1:0]);
   assign first_step = pattern_step(item.pattern_id, '0);

   always_comb begin
      nxt = cur;
      unique case (item.kind)
         KIND_TICK: begin
            if (cur.busy) begin
               if (cur.time_left <= DUR_W'(1)) begin
                  if (cur.in_pattern && (cur.current_pattern < PAT_COUNT) &&
                      (step_next < pattern_len(cur.current_pattern))) begin
                     nxt.step_index = step_next[STEP_W-1:0];
                     nxt.drive_freq = next_step.freq;
                     nxt.time_left  = next_step.dur;
                  end else begin
                     nxt.drive_freq = '0;
                     nxt.busy       = 1'b0;
                     nxt.in_pattern = 1'b0;
                  end
               end else begin
                  nxt.time_left = cur.time_left - DUR_W'(1);
               end
            end
         end
         KIND_TONE: begin
            nxt.busy       = 1'b1;
            nxt.in_pattern = 1'b0;
            nxt.drive_freq = item.tone_freq;
            nxt.time_left  = item.tone_duration;
         end
         KIND_PATTERN: begin
            if (item.pattern_id < PAT_COUNT) begin
               nxt.busy            = 1'b1;
               nxt.in_pattern      = 1'b1;
               nxt.current_pattern = item.pattern_id;
               nxt.step_index      = '0;
               nxt.drive_freq      = first_step.freq;
               nxt.time_left       = first_step.dur;
            end
         end
         default: begin
            // Unknown kind leaves the state alone.
            nxt = cur;
         end
      endcase
   end

endmodule

@@ rtl/buzzer_tone_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// Buzzer tone sequencer core
// Plays single tones and stored step patterns, counting down on millisecond
// ticks, and reports the buzzer frequency and activity after every item.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_    | in        | tuser = kind; tdata = tone_freq, tone_duration, pattern_id
//  rsp_    | out       | tdata = freq_out, playing
//
//  One transaction per cycle while the result side is not stalled; a request
//  passes the input register, then the state update into the result register.
//  The state update is the only loop: duration compare and decrement, step increment and limit compare, ROM reads.
//  Reset clears the sequencer state and both valid flags.
//  A stalled result holds the result stage and a full input stage; the input
//  side keeps taking a transaction while it is empty or the stage ahead of it can move.
// ----------------------------------------------------------------------------
module buzzer_tone_sequencer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [14:0] tone_freq, [30:15] tone_duration, [32:31] pattern_id, [39:33] zero
   input  logic [bts_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] kind
   input  logic [bts_pkg::KIND_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [14:0] freq_out, [15] playing
   output logic [bts_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import bts_pkg::*;

   logic          in_valid_ff, in_valid_in;
   item_type      in_item_ff, in_item_in;
   seq_state_type state_ff, state_in;
   seq_state_type state_calc;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic          out_move;
   logic          in_move;

   // The result stage moves when it is empty or being drained.
   assign out_move   = !rsp_valid_ff || rsp_tready;
   assign in_move    = !in_valid_ff || out_move;
   assign req_tready = in_move;

   bts_next u_next (
      .cur  (state_ff),
      .item (in_item_ff),
      .nxt  (state_calc)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_move) begin
         rsp_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            state_in    = state_calc;
            rsp_data_in = {state_calc.busy, state_calc.drive_freq};
         end
      end
      if (in_move) begin
         in_valid_in = req_tvalid;
         if (req_tvalid) begin
            in_item_in.kind          = req_tuser;
            in_item_in.tone_freq     = req_tdata[FREQ_W-1:0];
            in_item_in.tone_duration = req_tdata[FREQ_W+DUR_W-1:FREQ_W];
            in_item_in.pattern_id    = req_tdata[FREQ_W+DUR_W+PID_W-1:FREQ_W+DUR_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/bts_checker.sv @@
// ----------------------------------------------------------------------------
// Buzzer tone sequencer port checker
// Watches the core's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bts_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [bts_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [bts_pkg::KIND_W-1:0]      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bts_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import bts_pkg::*;

   // A stalled result keeps its contents.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // The buzzer is silent whenever nothing is playing.
   `ASSERT_IMPLIES(a_idle_silent, clock, reset, rsp_tvalid && !rsp_tdata[FREQ_W], rsp_tdata[FREQ_W-1:0] == '0)

   // No result can be presented right after reset.
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

   // With the result side stalled across an accepted request, the input is then not ready.
   `ASSERT_IMPLIES(a_backpressure, clock, reset, rsp_tvalid && !rsp_tready && $past(rsp_tvalid && !rsp_tready) && $past(req_tvalid && req_tready), !req_tready)

endmodule

bind buzzer_tone_sequencer_core bts_checker u_bts_checker (.*);
